/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; the using module provides clock and reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every edge outside reset
`define TCW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// check that pre is followed by post in the next cycle
`define TCW_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

/* hw/rtl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// Text console package
// Geometry, codes and transfer types shared by the console modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);

   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int CHAR_W  = 8;
   localparam int CELL_W  = 16;
   localparam int COLOR_W = 4;

   localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;

   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_SET   = 2'd3;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_FOREGROUND = 1'b0;
   localparam logic REG_BACKGROUND = 1'b1;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [CHAR_W-1:0] char_code;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
   } req_type;

   typedef struct packed {
      logic [COL_W-1:0]  cursor_col_out;
      logic [ROW_W-1:0]  cursor_row_out;
      logic [CELL_W-1:0] read_data;
      logic              scrolled;
      logic              position_ok;
   } rsp_type;

   typedef struct packed {
      logic [COLOR_W-1:0] foreground_color;
      logic [COLOR_W-1:0] background_color;
   } cfg_type;

endpackage

`default_nettype wire

/* hw/rtl/tcw_cell_ram.sv */
// ----------------------------------------------------------------------------
// Console cell memory
// One write port and one registered read port over the character cells.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_cell_ram
   import tcw_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [CELL_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [CELL_W-1:0] rd_data
);

   logic [CELL_W-1:0] mem [CELL_COUNT];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/tcw_ctrl.sv */
// ----------------------------------------------------------------------------
// Console controller
// Decodes operations, moves the cursor and sweeps the cell memory for
// clear, scroll and the post-reset blanking pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tcw_ctrl
   import tcw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [7:0] {
      S_INIT   = 8'b0000_0001,
      S_IDLE   = 8'b0000_0010,
      S_EXEC   = 8'b0000_0100,
      S_READ   = 8'b0000_1000,
      S_SCROLL = 8'b0001_0000,
      S_FLUSH  = 8'b0010_0000,
      S_BLANK  = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

   localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(CELL_COUNT - 1);
   localparam logic [ADDR_W-1:0] SCROLL_BASE = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] BOTTOM_BASE = ADDR_W'(CELL_COUNT - COLUMNS);
   localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] c,
                                                   input logic [ROW_W-1:0] r);
      cell_addr = ADDR_W'(32'(r) * COLUMNS + 32'(c));
   endfunction

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic [ADDR_W-1:0] wa_ff, wa_in;
   logic              pend_ff, pend_in;
   logic [CELL_W-1:0] rdata_ff, rdata_in;
   logic              scr_ff, scr_in;
   logic              ok_ff, ok_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CELL_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [CELL_W-1:0] rd_data;

   logic              in_range;
   logic [COL_W:0]    col_inc;
   logic              at_last_row;
   logic [CHAR_W-1:0] attr;

   tcw_cell_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign in_range    = (req_ff.col < COL_W'(COLUMNS)) && (req_ff.row < ROW_W'(ROWS));
   assign col_inc     = {1'b0, cur_col_ff} + (COL_W+1)'(1);
   assign at_last_row = cur_row_ff == LAST_ROW;
   assign attr        = {cfg.background_color, cfg.foreground_color};

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      sweep_in     = sweep_ff;
      wa_in        = wa_ff;
      pend_in      = pend_ff;
      rdata_in     = rdata_ff;
      scr_in       = scr_ff;
      ok_in        = ok_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_en        = 1'b0;
      wr_addr      = sweep_ff;
      wr_data      = BLANK_CELL;
      rd_en        = 1'b0;
      rd_addr      = sweep_ff;
      req_ready    = 1'b0;

      unique case (state_ff)
         S_INIT: begin
            wr_en = 1'b1;
            if (sweep_ff == LAST_ADDR) begin
               sweep_in = '0;
               state_in = S_IDLE;
            end else begin
               sweep_in = sweep_ff + ADDR_W'(1);
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            rdata_in = '0;
            scr_in   = 1'b0;
            ok_in    = 1'b0;
            pend_in  = 1'b0;
            state_in = S_DONE;
            unique case (req_ff.opcode)
               OP_PUT: begin
                  case (req_ff.char_code)
                     CH_RETURN: begin
                        cur_col_in = '0;
                     end
                     CH_BACKSPACE: begin
                        if (cur_col_ff != '0) begin
                           cur_col_in = cur_col_ff - COL_W'(1);
                           wr_en      = 1'b1;
                           wr_addr    = cell_addr(cur_col_ff - COL_W'(1), cur_row_ff);
                        end
                     end
                     default: begin
                        // newline, or a printable byte that wraps, goes to the next row
                        if (req_ff.char_code != CH_NEWLINE) begin
                           wr_en      = 1'b1;
                           wr_addr    = cell_addr(cur_col_ff, cur_row_ff);
                           wr_data    = {attr, req_ff.char_code};
                           cur_col_in = col_inc[COL_W-1:0];
                        end
                        if (req_ff.char_code == CH_NEWLINE ||
                            col_inc >= (COL_W+1)'(COLUMNS)) begin
                           cur_col_in = '0;
                           if (at_last_row) begin
                              scr_in   = 1'b1;
                              sweep_in = SCROLL_BASE;
                              state_in = S_SCROLL;
                           end else begin
                              cur_row_in = cur_row_ff + ROW_W'(1);
                           end
                        end
                     end
                  endcase
               end
               OP_READ: begin
                  if (in_range) begin
                     rd_en    = 1'b1;
                     rd_addr  = cell_addr(req_ff.col, req_ff.row);
                     ok_in    = 1'b1;
                     state_in = S_READ;
                  end
               end
               OP_CLEAR: begin
                  cur_col_in = '0;
                  cur_row_in = '0;
                  sweep_in   = '0;
                  state_in   = S_BLANK;
               end
               OP_SET: begin
                  if (in_range) begin
                     cur_col_in = req_ff.col;
                     cur_row_in = req_ff.row;
                     ok_in      = 1'b1;
                  end
               end
            endcase
         end
         S_READ: begin
            rdata_in = rd_data;
            state_in = S_DONE;
         end
         S_SCROLL: begin
            rd_en   = 1'b1;
            wa_in   = sweep_ff - SCROLL_BASE;
            pend_in = 1'b1;
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = wa_ff;
               wr_data = rd_data;
            end
            if (sweep_ff == LAST_ADDR) begin
               state_in = S_FLUSH;
            end else begin
               sweep_in = sweep_ff + ADDR_W'(1);
            end
         end
         S_FLUSH: begin
            wr_en    = 1'b1;
            wr_addr  = wa_ff;
            wr_data  = rd_data;
            pend_in  = 1'b0;
            sweep_in = BOTTOM_BASE;
            state_in = S_BLANK;
         end
         S_BLANK: begin
            wr_en = 1'b1;
            if (sweep_ff == LAST_ADDR) begin
               state_in = S_DONE;
            end else begin
               sweep_in = sweep_ff + ADDR_W'(1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.cursor_col_out = cur_col_ff;
               rsp_in.cursor_row_out = cur_row_ff;
               rsp_in.read_data      = rdata_ff;
               rsp_in.scrolled       = scr_ff;
               rsp_in.position_ok    = ok_ff;
               rsp_valid_in          = 1'b1;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         sweep_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         sweep_ff     <= sweep_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      wa_ff    <= wa_in;
      rdata_ff <= rdata_in;
      scr_ff   <= scr_in;
      ok_ff    <= ok_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `TCW_ASSERT(a_cursor_in_range,
      (cur_col_ff < COL_W'(COLUMNS)) && (cur_row_ff < ROW_W'(ROWS)),
      "cursor left the screen")
   `TCW_ASSERT(a_no_rw_collision, !(wr_en && rd_en && (wr_addr == rd_addr)),
      "read and write hit the same cell")
   `TCW_ASSERT(a_scroll_cursor,
      !(rsp_valid_ff && rsp_ff.scrolled) ||
      (rsp_ff.cursor_row_out == LAST_ROW && rsp_ff.cursor_col_out == '0),
      "scroll without cursor at start of last row")
   `TCW_ASSERT_NEXT(a_accept_exec, req_valid && req_ready, state_ff == S_EXEC,
      "accepted transfer not executed")

endmodule

`default_nettype wire

/* hw/rtl/text_console_writer.sv */
// ----------------------------------------------------------------------------
// Text console writer
// Character cell console with cursor, scroll and register-set colors.
//
// req_* carries one operation per transfer (put, read cell, clear, set
// cursor); rsp_* returns one result per operation with the final cursor.
// csr_* is an APB-style port: foreground color at 0x0, background at 0x4.
// Each accepted operation runs from an execute state to a done state that
// loads the result; an in-range read adds a read state between them, a
// put that scrolls copies each row up and then blanks the bottom row, and
// clear blanks every cell. Scroll and clear walk the cell memory one cell
// per cycle through its single write port. req_ready is high only while
// the controller is idle, from the cycle after each result is loaded, so
// the controller takes no new operation until the last result is loaded.
// One result may wait in the output register while the next operation runs,
// and the controller holds in its final cycle while rsp_ready stays low and
// that register is full. After reset a blanking pass fills all COLUMNS*ROWS
// (2000) cells with blank spaces before the first transfer is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer
   import tcw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg_ff, cfg_in;
   logic    csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_FOREGROUND: cfg_in.foreground_color = csr_pwdata[COLOR_W-1:0];
            REG_BACKGROUND: cfg_in.background_color = csr_pwdata[COLOR_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_FOREGROUND: csr_prdata = CSR_DATA_W'(cfg_ff.foreground_color);
         REG_BACKGROUND: csr_prdata = CSR_DATA_W'(cfg_ff.background_color);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.foreground_color <= COLOR_W'(15);
         cfg_ff.background_color <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
